// ----- rtl/bif_pkg.sv -----
// Package for the bilateral image filter: word types, register codes and constants.
// Has no dependencies; every rtl file refers to it by scoped names.
package bif_pkg;

   localparam int MAX_LINE_DEFAULT        = 2048;
   localparam int MAX_WINDOW_DEFAULT      = 9;
   localparam int EXP_TABLE_DEPTH_DEFAULT = 256;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int FRAME_W     = 12;
   localparam int WIN_W       = 4;
   localparam int INV_VAR_W   = 16;
   localparam int CHAN_W      = 8;
   localparam int PIX_W       = 3 * CHAN_W;
   localparam int S2_W        = 7;
   localparam int EXP_W       = 17;
   localparam int TAP_LATENCY = 7;
   localparam int FRAME_H_MAX = 2048;
   localparam int FRAME_MIN   = 3;

   localparam logic [FRAME_W-1:0]   FRAME_WIDTH_RESET   = 12'd640;
   localparam logic [FRAME_W-1:0]   FRAME_HEIGHT_RESET  = 12'd480;
   localparam logic [WIN_W-1:0]     WINDOW_SIZE_RESET   = 4'd5;
   localparam logic [INV_VAR_W-1:0] SPACE_INV_VAR_RESET = 16'd8192;
   localparam logic [INV_VAR_W-1:0] COLOR_INV_VAR_RESET = 16'd64;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH   = 3'd0,
      CSR_FRAME_HEIGHT  = 3'd1,
      CSR_WINDOW_SIZE   = 3'd2,
      CSR_SPACE_INV_VAR = 3'd3,
      CSR_COLOR_INV_VAR = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic              op;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              frame_last;
   } rsp_word_type;

   typedef struct packed {
      logic            valid;
      logic [S2_W-1:0] s2;
   } tap_req_type;

endpackage

// ----- rtl/bif_ram.sv -----
// Generic simple dual-port RAM, one write port and one registered read port.
// Uses bif_pkg for default width and depth only.
module bif_ram #(
   parameter int WIDTH = bif_pkg::PIX_W,
   parameter int DEPTH = (bif_pkg::MAX_WINDOW_DEFAULT + 1) * bif_pkg::MAX_LINE_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bif_tap.sv -----
// Tap weight pipeline: color distance, exponent, table weight and weighted sums.
// Depends on bif_pkg; fed one window tap per cycle with line store read data.
module bif_tap #(
   parameter int MAX_WINDOW      = bif_pkg::MAX_WINDOW_DEFAULT,
   parameter int EXP_TABLE_DEPTH = bif_pkg::EXP_TABLE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 clear,
   input  bif_pkg::tap_req_type                 tap_req,
   input  logic [bif_pkg::PIX_W-1:0]            rd_data,
   input  logic [bif_pkg::PIX_W-1:0]            center,
   input  logic [bif_pkg::INV_VAR_W-1:0]        space_inv_var,
   input  logic [bif_pkg::INV_VAR_W-1:0]        color_inv_var,
   output logic [$clog2(((2*((MAX_WINDOW-1)/2)+1)**2)+1)+bif_pkg::EXP_W+7:0] acc_red,
   output logic [$clog2(((2*((MAX_WINDOW-1)/2)+1)**2)+1)+bif_pkg::EXP_W+7:0] acc_green,
   output logic [$clog2(((2*((MAX_WINDOW-1)/2)+1)**2)+1)+bif_pkg::EXP_W+7:0] acc_blue,
   output logic [$clog2(((2*((MAX_WINDOW-1)/2)+1)**2)+1)+bif_pkg::EXP_W-1:0] acc_weight
);

   localparam int R_MAX   = (MAX_WINDOW - 1) / 2;
   localparam int TAP_MAX = (2 * R_MAX + 1) ** 2;
   localparam int EXP_W   = bif_pkg::EXP_W;
   localparam int WS_W    = $clog2(TAP_MAX + 1) + EXP_W;
   localparam int ACC_W   = WS_W + 8;
   localparam int IDX_W   = $clog2(EXP_TABLE_DEPTH);
   localparam int PROD_W  = 20 + $clog2(EXP_TABLE_DEPTH + 1);
   localparam int S2_W    = bif_pkg::S2_W;
   localparam int PIX_W   = bif_pkg::PIX_W;
   localparam int WP_W    = EXP_W + 8;

   typedef logic [EXP_W-1:0] exp_tab_type [EXP_TABLE_DEPTH];

   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 64'd0;
      rem = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic exp_tab_type build_exp_table();
      exp_tab_type       tab;
      longint unsigned   term;
      longint unsigned   a;
      longint unsigned   v;
      longint unsigned   div_k;
      term = 64'd1 << 32;
      a    = 64'd1 << 32;
      v    = 64'd1 << 32;
      for (int k = 1; k <= 16; k++) begin
         div_k = 64'(EXP_TABLE_DEPTH) * 64'(k);
         term  = udiv64(term * 64'd16, div_k);
         if ((k & 1) == 1) begin
            a = a - term;
         end else begin
            a = a + term;
         end
      end
      tab[0] = EXP_W'(65536);
      for (int i = 1; i < EXP_TABLE_DEPTH; i++) begin
         v      = (v * a) >> 32;
         tab[i] = EXP_W'((v + 64'd32768) >> 16);
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_table();

   logic             v0_ff, v1_ff, v2_ff, v3_ff;
   logic [S2_W-1:0]  s2_0_ff, s2_1_ff;
   logic [PIX_W-1:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic [17:0]      dist_ff;
   logic [34:0]      t_ff;
   logic             sat_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [EXP_W-1:0] wt_ff, wt5_ff;
   logic [WP_W-1:0]  pr_ff, pg_ff, pb_ff;
   logic [ACC_W-1:0] acc_red_ff, acc_green_ff, acc_blue_ff;
   logic [WS_W-1:0]  acc_weight_ff;

   logic signed [8:0]  dr, dg, db;
   logic signed [17:0] sqr, sqg, sqb;
   logic [17:0]        dist_in;
   logic [22:0]        ts;
   logic [33:0]        tc;
   logic [34:0]        t_in;
   logic [PROD_W-1:0]  scaled;
   logic [WP_W-1:0]    pr_in, pg_in, pb_in;

   always_comb begin
      dr      = $signed({1'b0, center[23:16]}) - $signed({1'b0, rd_data[23:16]});
      dg      = $signed({1'b0, center[15:8]}) - $signed({1'b0, rd_data[15:8]});
      db      = $signed({1'b0, center[7:0]}) - $signed({1'b0, rd_data[7:0]});
      sqr     = dr * dr;
      sqg     = dg * dg;
      sqb     = db * db;
      dist_in = unsigned'(sqr) + unsigned'(sqg) + unsigned'(sqb);
      ts      = s2_1_ff * space_inv_var;
      tc      = dist_ff * color_inv_var;
      t_in    = 35'(ts) + 35'(tc);
      scaled  = PROD_W'(t_ff[19:0]) * PROD_W'(EXP_TABLE_DEPTH);
      pr_in   = wt_ff * p4_ff[23:16];
      pg_in   = wt_ff * p4_ff[15:8];
      pb_in   = wt_ff * p4_ff[7:0];
   end

   // the registered read data of the line store lines up with stage 0
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= tap_req.valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_0_ff <= tap_req.s2;
      s2_1_ff <= s2_0_ff;
      p1_ff   <= rd_data;
      dist_ff <= dist_in;
      p2_ff   <= p1_ff;
      t_ff    <= t_in;
      p3_ff   <= p2_ff;
      sat_ff  <= |t_ff[34:20];
      idx_ff  <= scaled[20 +: IDX_W];
      p4_ff   <= p3_ff;
      wt_ff   <= (v3_ff && !sat_ff) ? EXP_TAB[idx_ff] : '0;
      wt5_ff  <= wt_ff;
      pr_ff   <= pr_in;
      pg_ff   <= pg_in;
      pb_ff   <= pb_in;
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         acc_red_ff    <= '0;
         acc_green_ff  <= '0;
         acc_blue_ff   <= '0;
         acc_weight_ff <= '0;
      end else begin
         acc_red_ff    <= acc_red_ff + ACC_W'(pr_ff);
         acc_green_ff  <= acc_green_ff + ACC_W'(pg_ff);
         acc_blue_ff   <= acc_blue_ff + ACC_W'(pb_ff);
         acc_weight_ff <= acc_weight_ff + WS_W'(wt5_ff);
      end
   end

   // v0 feeds v1 and s2_0 feeds s2_1; rd_data feeds p1 directly
   assign acc_red    = acc_red_ff;
   assign acc_green  = acc_green_ff;
   assign acc_blue   = acc_blue_ff;
   assign acc_weight = acc_weight_ff;

endmodule

// ----- rtl/bif_div_cell.sv -----
// One restoring division cell: settles one quotient bit for all three channels.
// Depends on bif_pkg for the channel width; cells are chained in the top level.
module bif_div_cell #(
   parameter int DIV_W = 34,
   parameter int WS_W  = 25,
   parameter int BIT   = 7
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  valid_in,
   input  logic [WS_W-1:0]                       divisor,
   input  logic [2:0][DIV_W-1:0]                 rem_in,
   input  logic [2:0][bif_pkg::CHAN_W-1:0]       quot_in,
   output logic                                  valid_out,
   output logic [2:0][DIV_W-1:0]                 rem_out,
   output logic [2:0][bif_pkg::CHAN_W-1:0]       quot_out
);

   logic                            valid_ff;
   logic [2:0][DIV_W-1:0]           rem_ff, rem_in_next;
   logic [2:0][bif_pkg::CHAN_W-1:0] quot_ff, quot_in_next;
   logic [DIV_W-1:0]                shifted;

   always_comb begin
      shifted      = DIV_W'(divisor) << BIT;
      rem_in_next  = rem_in;
      quot_in_next = quot_in;
      for (int c = 0; c < 3; c++) begin
         if (rem_in[c] >= shifted) begin
            rem_in_next[c]       = rem_in[c] - shifted;
            quot_in_next[c][BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in_next;
      quot_ff <= quot_in_next;
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign quot_out  = quot_ff;

endmodule

// ----- rtl/bilateral_image_filter_core.sv -----
// Bilateral image filter core. A word with no result returns to idle after the check state;
// a word that yields a pixel then runs the tap sequencer for window radius r, which reads
// one window tap per cycle from the single line store read port, then the 7-stage weight
// pipeline and the 8-cell divider chain. One word at a time.
// Synchronous reset restores register defaults and zeroes the position counters; the
// line store is not cleared. Depends on bif_pkg, bif_ram, bif_tap and bif_div_cell.
module bilateral_image_filter_core #(
   parameter int MAX_LINE        = bif_pkg::MAX_LINE_DEFAULT,
   parameter int MAX_WINDOW      = bif_pkg::MAX_WINDOW_DEFAULT,
   parameter int EXP_TABLE_DEPTH = bif_pkg::EXP_TABLE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  bif_pkg::req_word_type              req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output bif_pkg::rsp_word_type              rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  bif_pkg::csr_index_type             csr_index,
   input  logic [bif_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int RING    = MAX_WINDOW + 1;
   localparam int RING_W  = $clog2(RING);
   localparam int DEPTH   = RING * MAX_LINE;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COL_W   = $clog2(MAX_LINE);
   localparam int W_W     = ($clog2(MAX_LINE + 1) > bif_pkg::FRAME_W) ?
                            $clog2(MAX_LINE + 1) : bif_pkg::FRAME_W;
   localparam int ROW_W   = bif_pkg::FRAME_W;
   localparam int R_MAX   = (MAX_WINDOW - 1) / 2;
   localparam int DW      = $clog2(R_MAX + 1) + 1;
   localparam int TAP_MAX = (2 * R_MAX + 1) ** 2;
   localparam int WS_W    = $clog2(TAP_MAX + 1) + bif_pkg::EXP_W;
   localparam int ACC_W   = WS_W + 8;
   localparam int DIV_W   = ACC_W + 1;
   localparam int CNT_W   = $clog2(bif_pkg::TAP_LATENCY);
   localparam int PIX_W   = bif_pkg::PIX_W;
   localparam int CHAN_W  = bif_pkg::CHAN_W;
   localparam int S2_W    = bif_pkg::S2_W;

   typedef enum logic [7:0] {
      ST_IDLE        = 8'b0000_0001,
      ST_CHECK       = 8'b0000_0010,
      ST_CENTER      = 8'b0000_0100,
      ST_CENTER_WAIT = 8'b0000_1000,
      ST_TAPS        = 8'b0001_0000,
      ST_DRAIN       = 8'b0010_0000,
      ST_DIVIDE      = 8'b0100_0000,
      ST_FINISH      = 8'b1000_0000
   } state_type;

   function automatic logic [ADDR_W-1:0] line_addr(input logic [RING_W-1:0] ring,
                                                   input logic [COL_W-1:0]  col);
      return ADDR_W'(ring) * ADDR_W'(MAX_LINE) + ADDR_W'(col);
   endfunction

   // configuration registers
   logic [bif_pkg::FRAME_W-1:0]   frame_width_ff, frame_height_ff;
   logic [bif_pkg::WIN_W-1:0]     window_size_ff;
   logic [bif_pkg::INV_VAR_W-1:0] space_inv_var_ff, color_inv_var_ff;

   state_type             state_ff, state_in;
   logic [COL_W-1:0]      in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]      in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [RING_W-1:0]     in_ring_ff, in_ring_in, out_ring_ff, out_ring_in;
   logic signed [DW-1:0]  dy_ff, dy_in, dx_ff, dx_in;
   logic [CNT_W-1:0]      drain_ff, drain_in;
   logic                  pend_pix_ff, pend_pix_in;
   logic [PIX_W-1:0]      pend_data_ff, pend_data_in;
   logic [PIX_W-1:0]      center_ff, center_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   bif_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic [W_W-1:0]             w_eff;
   logic [ROW_W-1:0]           h_eff;
   logic [bif_pkg::WIN_W-1:0]  s_eff;
   logic signed [DW-1:0]       r_eff;

   logic                       item_take, pix, in_row_ok, out_ready, out_free, ended;
   logic [PIX_W-1:0]           pix_word;
   logic [W_W-1:0]             in_col_inc, out_col_inc;
   logic                       in_col_wrap, out_col_wrap;
   logic [RING_W-1:0]          in_ring_inc, out_ring_inc;
   logic [ROW_W-1:0]           out_row_next;
   logic [ROW_W:0]             nr;
   logic [W_W:0]               nc;

   logic signed [ROW_W+1:0]    tap_y;
   logic signed [W_W+1:0]      tap_x;
   logic signed [RING_W+1:0]   ring_s;
   logic [RING_W-1:0]          tap_ring;
   logic signed [2*DW-1:0]     dxx, dyy;
   bif_pkg::tap_req_type       tap_req;

   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr, rd_addr;
   logic [PIX_W-1:0]           wr_data, rd_data;

   logic [ACC_W-1:0]           acc_red, acc_green, acc_blue;
   logic [WS_W-1:0]            acc_weight;

   logic [8:0]                        chain_valid;
   logic [2:0][DIV_W-1:0]             chain_rem  [9];
   logic [2:0][CHAN_W-1:0]            chain_quot [9];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= bif_pkg::FRAME_WIDTH_RESET;
         frame_height_ff  <= bif_pkg::FRAME_HEIGHT_RESET;
         window_size_ff   <= bif_pkg::WINDOW_SIZE_RESET;
         space_inv_var_ff <= bif_pkg::SPACE_INV_VAR_RESET;
         color_inv_var_ff <= bif_pkg::COLOR_INV_VAR_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            bif_pkg::CSR_FRAME_WIDTH:   frame_width_ff   <= csr_data[bif_pkg::FRAME_W-1:0];
            bif_pkg::CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_data[bif_pkg::FRAME_W-1:0];
            bif_pkg::CSR_WINDOW_SIZE:   window_size_ff   <= csr_data[bif_pkg::WIN_W-1:0];
            bif_pkg::CSR_SPACE_INV_VAR: space_inv_var_ff <= csr_data;
            bif_pkg::CSR_COLOR_INV_VAR: color_inv_var_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // effective frame and window sizes
   always_comb begin
      if (frame_width_ff < bif_pkg::FRAME_W'(bif_pkg::FRAME_MIN)) begin
         w_eff = W_W'(bif_pkg::FRAME_MIN);
      end else if (W_W'(frame_width_ff) > W_W'(MAX_LINE)) begin
         w_eff = W_W'(MAX_LINE);
      end else begin
         w_eff = W_W'(frame_width_ff);
      end
      if (frame_height_ff < ROW_W'(bif_pkg::FRAME_MIN)) begin
         h_eff = ROW_W'(bif_pkg::FRAME_MIN);
      end else if (frame_height_ff > ROW_W'(bif_pkg::FRAME_H_MAX)) begin
         h_eff = ROW_W'(bif_pkg::FRAME_H_MAX);
      end else begin
         h_eff = frame_height_ff;
      end
      if (window_size_ff < bif_pkg::WIN_W'(3)) begin
         s_eff = bif_pkg::WIN_W'(3);
      end else if (window_size_ff > bif_pkg::WIN_W'(MAX_WINDOW)) begin
         s_eff = bif_pkg::WIN_W'(MAX_WINDOW);
      end else begin
         s_eff = window_size_ff;
      end
      r_eff = DW'((s_eff - bif_pkg::WIN_W'(1)) >> 1);
   end

   always_comb begin
      item_take    = req_valid && (state_ff == ST_IDLE);
      pix          = req_data.op == bif_pkg::OP_PIXEL;
      pix_word     = {req_data.red_in, req_data.green_in, req_data.blue_in};
      in_row_ok    = in_row_ff < h_eff;
      in_col_inc   = W_W'(in_col_ff) + W_W'(1);
      in_col_wrap  = in_col_inc >= w_eff;
      in_ring_inc  = (in_ring_ff == RING_W'(RING - 1)) ? '0 : in_ring_ff + RING_W'(1);
      out_col_inc  = W_W'(out_col_ff) + W_W'(1);
      out_col_wrap = out_col_inc >= w_eff;
      out_ring_inc = (out_ring_ff == RING_W'(RING - 1)) ? '0 : out_ring_ff + RING_W'(1);
      out_row_next = out_col_wrap ? out_row_ff + ROW_W'(1) : out_row_ff;
      ended        = out_row_next >= h_eff;
      out_free     = !rsp_valid_ff || !rsp_stall;

      nr = (ROW_W+1)'(out_row_ff) + (ROW_W+1)'(unsigned'(r_eff));
      if (nr > (ROW_W+1)'(h_eff - ROW_W'(1))) begin
         nr = (ROW_W+1)'(h_eff - ROW_W'(1));
      end
      nc = (W_W+1)'(out_col_ff) + (W_W+1)'(unsigned'(r_eff));
      if (nc > (W_W+1)'(w_eff - W_W'(1))) begin
         nc = (W_W+1)'(w_eff - W_W'(1));
      end
      out_ready = !in_row_ok || ((ROW_W+1)'(in_row_ff) > nr) ||
                  (((ROW_W+1)'(in_row_ff) == nr) && ((W_W+1)'(in_col_ff) > nc));
   end

   // window tap position and ring row
   always_comb begin
      tap_y  = $signed({2'b00, out_row_ff}) + (ROW_W+2)'(dy_ff);
      tap_x  = $signed({{(W_W+2-COL_W){1'b0}}, out_col_ff}) + (W_W+2)'(dx_ff);
      ring_s = $signed({2'b00, out_ring_ff}) + (RING_W+2)'(dy_ff);
      if (ring_s < 0) begin
         ring_s = ring_s + (RING_W+2)'(RING);
      end else if (ring_s >= $signed((RING_W+2)'(RING))) begin
         ring_s = ring_s - (RING_W+2)'(RING);
      end
      tap_ring = ring_s[RING_W-1:0];
      dxx      = dx_ff * dx_ff;
      dyy      = dy_ff * dy_ff;
      tap_req.s2    = S2_W'(dxx) + S2_W'(dyy);
      tap_req.valid = (state_ff == ST_TAPS) && (tap_y >= 0) &&
                      (tap_y < $signed({2'b00, h_eff})) && (tap_x >= 0) &&
                      (tap_x < $signed({2'b00, w_eff}));
      if (state_ff == ST_CENTER) begin
         rd_addr = line_addr(out_ring_ff, out_col_ff);
      end else begin
         rd_addr = line_addr(tap_ring, tap_x[COL_W-1:0]);
      end
   end

   always_comb begin
      if (state_ff == ST_FINISH) begin
         wr_en   = out_free && ended && pend_pix_ff;
         wr_addr = line_addr('0, '0);
         wr_data = pend_data_ff;
      end else begin
         wr_en   = item_take && pix && in_row_ok;
         wr_addr = line_addr(in_ring_ff, in_col_ff);
         wr_data = pix_word;
      end
   end

   always_comb begin
      state_in     = state_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      in_ring_in   = in_ring_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_ring_in  = out_ring_ff;
      dy_in        = dy_ff;
      dx_in        = dx_ff;
      drain_in     = drain_ff;
      pend_pix_in  = pend_pix_ff;
      pend_data_in = pend_data_ff;
      center_in    = center_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (item_take) begin
               pend_data_in = pix_word;
               pend_pix_in  = pix && !in_row_ok;
               if (pix && in_row_ok) begin
                  if (in_col_wrap) begin
                     in_col_in  = '0;
                     in_row_in  = in_row_ff + ROW_W'(1);
                     in_ring_in = in_ring_inc;
                  end else begin
                     in_col_in = COL_W'(in_col_inc);
                  end
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = out_ready ? ST_CENTER : ST_IDLE;
         end
         ST_CENTER: begin
            state_in = ST_CENTER_WAIT;
         end
         ST_CENTER_WAIT: begin
            center_in = rd_data;
            dy_in     = -r_eff;
            dx_in     = -r_eff;
            state_in  = ST_TAPS;
         end
         ST_TAPS: begin
            if (dx_ff == r_eff) begin
               dx_in = -r_eff;
               if (dy_ff == r_eff) begin
                  drain_in = CNT_W'(bif_pkg::TAP_LATENCY - 1);
                  state_in = ST_DRAIN;
               end else begin
                  dy_in = dy_ff + DW'(1);
               end
            end else begin
               dx_in = dx_ff + DW'(1);
            end
         end
         ST_DRAIN: begin
            if (drain_ff == '0) begin
               state_in = ST_DIVIDE;
            end else begin
               drain_in = drain_ff - CNT_W'(1);
            end
         end
         ST_DIVIDE: begin
            if (chain_valid[8]) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (acc_weight == '0) begin
                  rsp_data_in.red_out   = '0;
                  rsp_data_in.green_out = '0;
                  rsp_data_in.blue_out  = '0;
               end else begin
                  rsp_data_in.red_out   = chain_quot[8][0];
                  rsp_data_in.green_out = chain_quot[8][1];
                  rsp_data_in.blue_out  = chain_quot[8][2];
               end
               rsp_data_in.frame_last = ended;
               if (out_col_wrap) begin
                  out_col_in  = '0;
                  out_row_in  = out_row_next;
                  out_ring_in = out_ring_inc;
               end else begin
                  out_col_in = COL_W'(out_col_inc);
               end
               if (ended) begin
                  out_col_in  = '0;
                  out_row_in  = '0;
                  out_ring_in = '0;
                  in_col_in   = '0;
                  in_row_in   = '0;
                  in_ring_in  = '0;
                  if (pend_pix_ff) begin
                     in_col_in = COL_W'(1);
                  end
               end
               pend_pix_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_ring_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_ring_ff  <= '0;
         dy_ff        <= '0;
         dx_ff        <= '0;
         drain_ff     <= '0;
         pend_pix_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_ring_ff   <= in_ring_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_ring_ff  <= out_ring_in;
         dy_ff        <= dy_in;
         dx_ff        <= dx_in;
         drain_ff     <= drain_in;
         pend_pix_ff  <= pend_pix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_data_ff <= pend_data_in;
      center_ff    <= center_in;
      rsp_data_ff  <= rsp_data_in;
   end

   bif_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bif_tap #(
      .MAX_WINDOW      (MAX_WINDOW),
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_tap (
      .clock         (clock),
      .reset         (reset),
      .clear         (state_ff == ST_CENTER),
      .tap_req       (tap_req),
      .rd_data       (rd_data),
      .center        (center_ff),
      .space_inv_var (space_inv_var_ff),
      .color_inv_var (color_inv_var_ff),
      .acc_red       (acc_red),
      .acc_green     (acc_green),
      .acc_blue      (acc_blue),
      .acc_weight    (acc_weight)
   );

   // rounding: add half the weight sum before the divide
   assign chain_valid[0]   = (state_ff == ST_DRAIN) && (drain_ff == '0);
   assign chain_rem[0][0]  = DIV_W'(acc_red) + DIV_W'(acc_weight >> 1);
   assign chain_rem[0][1]  = DIV_W'(acc_green) + DIV_W'(acc_weight >> 1);
   assign chain_rem[0][2]  = DIV_W'(acc_blue) + DIV_W'(acc_weight >> 1);
   assign chain_quot[0]    = '0;

   for (genvar i = 0; i < 8; i++) begin : g_div
      bif_div_cell #(
         .DIV_W (DIV_W),
         .WS_W  (WS_W),
         .BIT   (7 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (chain_valid[i]),
         .divisor   (acc_weight),
         .rem_in    (chain_rem[i]),
         .quot_in   (chain_quot[i]),
         .valid_out (chain_valid[i+1]),
         .rem_out   (chain_rem[i+1]),
         .quot_out  (chain_quot[i+1])
      );
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sim/bilateral_image_filter_core_test.sv -----
// Self-checking testbench for bilateral_image_filter_core: streams RGB frames with flush words,
// predicts each filtered pixel in step with accepted words and checks the result stream.
// Depends on bif_pkg and the filter core RTL.
module bilateral_image_filter_core_test;
   import bif_pkg::*;

   localparam int LINE_MAX = 2048;
   localparam int WIN_MAX  = 9;
   localparam int RING     = WIN_MAX + 1;
   localparam int EXP_N    = 256;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   bilateral_image_filter_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // filter shadow state
   logic [11:0]  width_reg, height_reg;
   logic [3:0]   win_reg;
   logic [15:0]  space_reg, color_reg;
   logic [23:0]  line_mem [0:RING*LINE_MAX-1];
   int unsigned  in_col, in_row, out_col, out_row;
   int unsigned  gauss_lut [0:EXP_N-1];

   req_word_type pending_words[$];
   rsp_word_type expected_pixels[$];
   int errors = 0, words_in = 0, pixels_out = 0, frames_done = 0;
   int gap_left = 0, burst_left = 0, stall_tick = 0, stall_mode = 0;

   function automatic void build_lut();
      longint unsigned term, a, v;
      term = 64'd1 << 32;
      a = 64'd1 << 32;
      v = 64'd1 << 32;
      for (int k = 1; k <= 16; k++) begin
         term = term * 16 / (EXP_N * k);
         if (k % 2 == 1) a -= term; else a += term;
      end
      gauss_lut[0] = 65536;
      for (int i = 1; i < EXP_N; i++) begin
         v = (v * a) >> 32;
         gauss_lut[i] = int'((v + 32768) >> 16);
      end
   endfunction

   function automatic int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > LINE_MAX) w = LINE_MAX;
      return w;
   endfunction

   function automatic int unsigned eff_height();
      int unsigned h;
      h = height_reg;
      if (h < 3) h = 3;
      if (h > 2048) h = 2048;
      return h;
   endfunction

   function automatic int unsigned radius();
      int unsigned s;
      s = win_reg;
      if (s < 3) s = 3;
      if (s > WIN_MAX) s = WIN_MAX;
      if (s % 2 == 0) s -= 1;
      return s / 2;
   endfunction

   function automatic logic [23:0] read_line(int unsigned row, int unsigned col);
      if (col >= LINE_MAX) return '0;
      return line_mem[(row % RING) * LINE_MAX + col];
   endfunction

   function automatic void store_pixel(req_word_type w);
      if (in_col < LINE_MAX)
         line_mem[(in_row % RING) * LINE_MAX + in_col] = {w.red_in, w.green_in, w.blue_in};
      in_col++;
      if (in_col >= eff_width()) begin
         in_col = 0;
         in_row++;
      end
   endfunction

   function automatic bit output_ready();
      int unsigned nr, nc;
      nr = out_row + radius();
      nc = out_col + radius();
      if (nr > eff_height() - 1) nr = eff_height() - 1;
      if (nc > eff_width() - 1) nc = eff_width() - 1;
      if (in_row >= eff_height()) return 1;
      return in_row > nr || (in_row == nr && in_col > nc);
   endfunction

   function automatic bit filter_pixel();
      int w, h, r, y, x, d0, d1, d2;
      logic [23:0] pc, p;
      longint unsigned t, idx, wt, ws;
      longint unsigned sum [3];
      rsp_word_type o;
      w = eff_width();
      h = eff_height();
      r = radius();
      pc = read_line(out_row, out_col);
      ws = 0;
      sum[0] = 0; sum[1] = 0; sum[2] = 0;
      for (int dy = -r; dy <= r; dy++) begin
         y = int'(out_row) + dy;
         if (y < 0 || y >= h) continue;
         for (int dx = -r; dx <= r; dx++) begin
            x = int'(out_col) + dx;
            if (x < 0 || x >= w) continue;
            p = read_line(y, x);
            d0 = int'(pc[23:16]) - int'(p[23:16]);
            d1 = int'(pc[15:8]) - int'(p[15:8]);
            d2 = int'(pc[7:0]) - int'(p[7:0]);
            t = longint'(dx * dx + dy * dy) * space_reg
              + longint'(d0 * d0 + d1 * d1 + d2 * d2) * color_reg;
            idx = (t * EXP_N) >> 20;
            wt = idx < EXP_N ? gauss_lut[idx] : 0;
            sum[0] += wt * p[23:16];
            sum[1] += wt * p[15:8];
            sum[2] += wt * p[7:0];
            ws += wt;
         end
      end
      for (int c = 0; c < 3; c++)
         if (ws != 0) begin
            sum[c] = (sum[c] + ws / 2) / ws;
            if (sum[c] > 255) sum[c] = 255;
         end else sum[c] = 0;
      o.red_out = sum[0][7:0];
      o.green_out = sum[1][7:0];
      o.blue_out = sum[2][7:0];
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      o.frame_last = out_row >= h;
      expected_pixels.push_back(o);
      if (o.frame_last) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
      return o.frame_last;
   endfunction

   function automatic void filter_step(req_word_type w);
      bit pix, taken, ended;
      pix = w.op == OP_PIXEL;
      taken = 0;
      ended = 0;
      if (pix && in_row < eff_height()) begin
         store_pixel(w);
         taken = 1;
      end
      if (output_ready()) ended = filter_pixel();
      if (pix && !taken && ended) store_pixel(w);
   endfunction

   function automatic void apply_csr(csr_index_type idx, logic [15:0] d);
      case (idx)
         CSR_FRAME_WIDTH:   width_reg = d[11:0];
         CSR_FRAME_HEIGHT:  height_reg = d[11:0];
         CSR_WINDOW_SIZE:   win_reg = d[3:0];
         CSR_SPACE_INV_VAR: space_reg = d;
         CSR_COLOR_INV_VAR: color_reg = d;
         default: ;
      endcase
   endfunction

   // driver: bursts with random gaps, hold while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            filter_step(req_data);
            words_in++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || pending_words.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end else begin
               req_valid <= 1'b1;
               req_data <= pending_words.pop_front();
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // monitor: check each accepted word, stall on a shifting pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_data);
               errors++;
            end else begin
               rsp_word_type e;
               e = expected_pixels.pop_front();
               if (rsp_data.red_out !== e.red_out) begin
                  $display("%0t: red_out expected %0d actual %0d", $time, e.red_out,
                           rsp_data.red_out);
                  errors++;
               end
               if (rsp_data.green_out !== e.green_out) begin
                  $display("%0t: green_out expected %0d actual %0d", $time, e.green_out,
                           rsp_data.green_out);
                  errors++;
               end
               if (rsp_data.blue_out !== e.blue_out) begin
                  $display("%0t: blue_out expected %0d actual %0d", $time, e.blue_out,
                           rsp_data.blue_out);
                  errors++;
               end
               if (rsp_data.frame_last !== e.frame_last) begin
                  $display("%0t: frame_last expected %0d actual %0d", $time, e.frame_last,
                           rsp_data.frame_last);
                  errors++;
               end
               pixels_out++;
               if (e.frame_last) frames_done++;
            end
         end
         stall_tick++;
         if (stall_tick % 256 == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= (stall_tick % 9) < 4;
         endcase
      end
   end

   task automatic csr_write(csr_index_type idx, logic [15:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, d);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_sent();
      do @(posedge clock); while (pending_words.size() != 0 || req_valid);
   endtask

   task automatic settle();
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (130) @(posedge clock);
   endtask

   function automatic req_word_type make_word(bit flush, logic [23:0] base, int spread);
      req_word_type w;
      w.op = flush ? OP_FLUSH : OP_PIXEL;
      if (spread >= 255) begin
         w.red_in = 8'($urandom); w.green_in = 8'($urandom); w.blue_in = 8'($urandom);
      end else begin
         w.red_in = base[23:16] ^ 8'($urandom_range(0, spread));
         w.green_in = base[15:8] ^ 8'($urandom_range(0, spread));
         w.blue_in = base[7:0] ^ 8'($urandom_range(0, spread));
      end
      return w;
   endfunction

   // one frame from the current position, then drain with flush words (some pixel words when noisy)
   task automatic run_frame(bit noisy);
      int n;
      logic [23:0] base;
      int spread;
      wait_sent();
      base = 24'($urandom);
      spread = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(0, 31);
      n = (in_row >= eff_height()) ? 0 : (eff_height() - in_row) * eff_width() - in_col;
      for (int i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 19) == 0) pending_words.push_back(make_word(1, base, 255));
         pending_words.push_back(make_word(0, base, spread));
      end
      wait_sent();
      n = eff_width() * eff_height() - (out_row * eff_width() + out_col);
      for (int i = 0; i < n; i++)
         pending_words.push_back(make_word(!(noisy && $urandom_range(0, 3) == 0), base, 255));
      wait_sent();
   endtask

   task automatic finish_frames();
      while (in_col != 0 || in_row != 0 || out_col != 0 || out_row != 0) run_frame(0);
      settle();
   endtask

   task automatic configure(logic [15:0] w, logic [15:0] h, logic [15:0] s,
                            logic [15:0] sv, logic [15:0] cv);
      csr_write(CSR_FRAME_WIDTH, w);
      csr_write(CSR_FRAME_HEIGHT, h);
      csr_write(CSR_WINDOW_SIZE, s);
      csr_write(CSR_SPACE_INV_VAR, sv);
      csr_write(CSR_COLOR_INV_VAR, cv);
   endtask

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int start;
      logic [15:0] sizes [8];
      sizes = '{0, 3, 4, 5, 7, 8, 9, 15};
      width_reg = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      win_reg = WINDOW_SIZE_RESET;
      space_reg = SPACE_INV_VAR_RESET;
      color_reg = COLOR_INV_VAR_RESET;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      build_lut();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 3x3 frame: extreme pixels, flush with nothing ready, pixel past a full frame
      configure(16'hF003, 16'h0003, 16'd3, 16'd8192, 16'd16);
      pending_words.push_back('{OP_FLUSH, 8'h00, 8'h00, 8'h00});
      pending_words.push_back('{OP_PIXEL, 8'hFF, 8'hFF, 8'hFF});
      pending_words.push_back('{OP_PIXEL, 8'h00, 8'h00, 8'h00});
      pending_words.push_back('{OP_PIXEL, 8'hFF, 8'h00, 8'hFF});
      pending_words.push_back('{OP_PIXEL, 8'h00, 8'hFF, 8'h00});
      pending_words.push_back('{OP_PIXEL, 8'h80, 8'h7F, 8'h01});
      pending_words.push_back('{OP_PIXEL, 8'hFE, 8'h01, 8'h80});
      pending_words.push_back('{OP_PIXEL, 8'h55, 8'hAA, 8'h55});
      pending_words.push_back('{OP_PIXEL, 8'hAA, 8'h55, 8'hAA});
      pending_words.push_back('{OP_PIXEL, 8'h11, 8'h22, 8'h33});
      pending_words.push_back('{OP_FLUSH, 8'hFF, 8'hFF, 8'hFF});
      pending_words.push_back('{OP_PIXEL, 8'h10, 8'h20, 8'h30});
      pending_words.push_back('{OP_FLUSH, 8'h00, 8'h00, 8'h00});
      pending_words.push_back('{OP_PIXEL, 8'h40, 8'h50, 8'h60});
      wait_sent();
      finish_frames();
      configure(16'h0000, 16'hF000, 16'd0, 16'd0, 16'd65535);
      run_frame(0);
      finish_frames();

      start = words_in;
      while (words_in - start < 550) begin
         configure(16'($urandom_range(0, 12) | ($urandom_range(0, 15) << 12)),
                   16'($urandom_range(0, 8) | ($urandom_range(0, 15) << 12)),
                   16'(sizes[$urandom_range(0, 7)] | ($urandom_range(0, 4095) << 4)),
                   ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(0, 40000)),
                   ($urandom_range(0, 5) == 0) ? 16'hFFFF :
                   ($urandom_range(0, 5) == 0) ? 16'h0000 : 16'($urandom_range(1, 300)));
         repeat ($urandom_range(1, 2)) run_frame($urandom_range(0, 3) != 0);
         finish_frames();
      end

      // wide and tall frames
      configure(16'd32, 16'd3, 16'd3, 16'd20000, 16'd40);
      run_frame(0);
      finish_frames();
      configure(16'd3, 16'd32, 16'd3, 16'd65535, 16'd0);
      run_frame(0);
      finish_frames();

      $display("Sent %0d words; checked %0d filtered pixels over %0d frames",
               words_in, pixels_out, frames_done);
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
